@@ src/ile_pkg.sv @@
// shared types and codes for the indexed list engine
// no dependencies; imported by indexed_list_engine
package ile_pkg;

  localparam int unsigned DefCapacity = 64;

  // operation codes
  localparam logic [2:0] KIND_GET     = 3'd0;
  localparam logic [2:0] KIND_INS_HD  = 3'd1;
  localparam logic [2:0] KIND_INS_TL  = 3'd2;
  localparam logic [2:0] KIND_INS_POS = 3'd3;
  localparam logic [2:0] KIND_DEL_POS = 3'd4;

  // status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic signed [31:0] NoneValue = -32'sd1;

  typedef struct packed {
    logic        [2:0]  kind;
    logic signed [15:0] position;
    logic signed [31:0] value_in;
  } ile_cmd_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic        [1:0]  status;
    logic        [6:0]  length;
  } ile_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_SHIFT,
    ST_INS_LAST,
    ST_DEL_SHIFT
  } ile_state_e;

endpackage

@@ src/indexed_list_engine.sv @@
// indexed list engine: ordered list of signed 32-bit words kept packed in one memory
// depends on ile_pkg (command/result structs, codes, state enum)
// latency: every result is strobed on res_valid_o in the cycle after its command word is taken
// throughput: get, append, rejected ops and delete of the last entry never raise busy; an
//   insert at p keeps busy high while entries p and up move up and the new word is written, a
//   delete at p while entries above p move down; one entry moved per cycle, single write port
// reset: asynchronous, active low; clears the entry count and control state, memory is not
//   cleared (entries beyond the count are never read); results cannot be stalled
module indexed_list_engine #(
  parameter int unsigned CAPACITY = ile_pkg::DefCapacity
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ile_pkg::ile_cmd_t cmd_i,
  output logic             res_valid_o,
  output ile_pkg::ile_res_t res_o
);
  import ile_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // list storage, one synchronous read port and one write port
  logic [31:0] mem [CAPACITY];
  logic [31:0] rdata_q;

  logic          we_c;
  logic [AW-1:0] waddr_c;
  logic [31:0]   wdata_c;
  logic [AW-1:0] raddr_c;

  ile_state_e    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] rd_q, rd_d;     // last address read during a shift
  logic [AW-1:0] lim_q, lim_d;   // address at which the shift stops
  logic [31:0]   val_q, val_d;   // word waiting for its slot after an insert shift

  logic     res_valid_q, res_valid_d;
  ile_res_t res_q, res_d;
  logic     get_sel_q, get_sel_d;

  // decode of the incoming command
  logic          acc;
  logic          pos_neg;
  logic [15:0]   pos_u;
  logic [15:0]   cnt_w;
  logic          lt_cnt, le_cnt, full;
  logic [AW-1:0] pos_a;
  logic [AW-1:0] ins_p;
  logic          is_ins;
  logic          do_get, do_ins, do_del;
  logic          ins_shift, del_shift;
  logic [1:0]    status_c;

  assign busy = (state_q != ST_IDLE);
  assign acc  = start & ~busy;

  always_comb begin
    pos_neg = cmd_i.position[15];
    pos_u   = cmd_i.position;
    cnt_w   = 16'(cnt_q);
    lt_cnt  = !pos_neg && (pos_u < cnt_w);
    le_cnt  = !pos_neg && (pos_u <= cnt_w);
    full    = (cnt_q == CW'(CAPACITY));
    pos_a   = pos_u[AW-1:0];
    is_ins  = 1'b0;
    ins_p   = pos_a;
    status_c = STATUS_DONE;
    unique case (cmd_i.kind)
      KIND_GET: begin
        if (!lt_cnt) status_c = STATUS_RANGE;
      end
      KIND_INS_HD: begin
        ins_p = '0;
        if (full) status_c = STATUS_FULL;
        else      is_ins   = 1'b1;
      end
      KIND_INS_TL: begin
        ins_p = cnt_q[AW-1:0];
        if (full) status_c = STATUS_FULL;
        else      is_ins   = 1'b1;
      end
      KIND_INS_POS: begin
        if (!le_cnt)   status_c = STATUS_RANGE;
        else if (full) status_c = STATUS_FULL;
        else           is_ins   = 1'b1;
      end
      KIND_DEL_POS: begin
        if (!lt_cnt) status_c = STATUS_RANGE;
      end
      default: begin
        status_c = STATUS_RANGE;
      end
    endcase
    do_get    = acc && (cmd_i.kind == KIND_GET) && lt_cnt;
    do_ins    = acc && is_ins;
    do_del    = acc && (cmd_i.kind == KIND_DEL_POS) && lt_cnt;
    // entries above the insert point must move up one slot first
    ins_shift = do_ins && (CW'(ins_p) != cnt_q);
    // entries above the deleted one move down unless it was the last
    del_shift = do_del && (CW'(pos_a) != (cnt_q - CW'(1)));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ins_shift)      state_d = ST_INS_SHIFT;
        else if (del_shift) state_d = ST_DEL_SHIFT;
      end
      ST_INS_SHIFT: begin
        if (rd_q == lim_q) state_d = ST_INS_LAST;
      end
      ST_INS_LAST: begin
        state_d = ST_IDLE;
      end
      ST_DEL_SHIFT: begin
        if (rd_q == lim_q) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // memory ports, count and shift pointers
  always_comb begin
    we_c    = 1'b0;
    waddr_c = rd_q;
    wdata_c = rdata_q;
    raddr_c = rd_q;
    rd_d    = rd_q;
    lim_d   = lim_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (do_get) begin
          raddr_c = pos_a;
        end else if (ins_shift) begin
          // start from the top entry and walk down
          raddr_c = AW'(cnt_q - CW'(1));
          rd_d    = AW'(cnt_q - CW'(1));
          lim_d   = ins_p;
          val_d   = cmd_i.value_in;
        end else if (do_ins) begin
          // append: slot is free already
          we_c    = 1'b1;
          waddr_c = ins_p;
          wdata_c = cmd_i.value_in;
        end else if (del_shift) begin
          raddr_c = pos_a + AW'(1);
          rd_d    = pos_a + AW'(1);
          lim_d   = AW'(cnt_q - CW'(1));
        end
        if (do_ins)      cnt_d = cnt_q + CW'(1);
        else if (do_del) cnt_d = cnt_q - CW'(1);
      end
      ST_INS_SHIFT: begin
        we_c    = 1'b1;
        waddr_c = rd_q + AW'(1);
        wdata_c = rdata_q;
        if (rd_q != lim_q) begin
          raddr_c = rd_q - AW'(1);
          rd_d    = rd_q - AW'(1);
        end
      end
      ST_INS_LAST: begin
        we_c    = 1'b1;
        waddr_c = lim_q;
        wdata_c = val_q;
      end
      ST_DEL_SHIFT: begin
        we_c    = 1'b1;
        waddr_c = rd_q - AW'(1);
        wdata_c = rdata_q;
        if (rd_q != lim_q) begin
          raddr_c = rd_q + AW'(1);
          rd_d    = rd_q + AW'(1);
        end
      end
      default: begin
        we_c = 1'b0;
      end
    endcase
  end

  // result word is known at accept time, only the get data waits for the memory
  always_comb begin
    res_valid_d       = acc;
    get_sel_d         = do_get;
    res_d             = res_q;
    if (acc) begin
      res_d.read_value = NoneValue;
      res_d.status     = status_c;
      res_d.length     = 7'(cnt_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_c) mem[waddr_c] <= wdata_c;
    rdata_q <= mem[raddr_c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      get_sel_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      get_sel_q   <= get_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q  <= rd_d;
    lim_q <= lim_d;
    val_q <= val_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  always_comb begin
    res_o = res_q;
    if (get_sel_q) res_o.read_value = rdata_q;
  end

  // a shift only runs over a non-empty list
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> (cnt_q != '0))
    else $error("shift running with empty list");

  // every taken command yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) acc |=> res_valid_q)
    else $error("result missing after accepted command");

  // insert shift writes stay below the new count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS_SHIFT) |-> ((CW'(rd_q) + CW'(1)) < cnt_q))
    else $error("insert shift beyond list end");

  // delete shift reads stay within the old list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEL_SHIFT) |-> (CW'(rd_q) <= cnt_q))
    else $error("delete shift beyond list end");

  // full status only when the list is at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.status == STATUS_FULL)) |-> (cnt_q == CW'(CAPACITY)))
    else $error("full status below capacity");

endmodule

@@ verif/tb_indexed_list_engine.sv @@
// self-checking testbench for indexed_list_engine: directed and random list operations
// keeps its own copy of the list to predict each result word; depends on ile_pkg and the rtl
module tb_indexed_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ile_pkg::*;

  localparam int unsigned ListDepth = DefCapacity;
  // idle cycles with no word moving in either direction before the run is called hung;
  // the longest legal quiet stretch is a full-depth shift plus a gap
  localparam int unsigned WatchdogLimit = 2000;
  // settle time after the last result word, covers the longest shift
  localparam int unsigned TailCycles = ListDepth + 16;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  ile_cmd_t  cmd;
  logic      res_valid;
  ile_res_t  res;

  // shadow copy of the list, head at index 0
  logic signed [31:0] shadow_list[$];
  // result words owed by the block, oldest first
  ile_res_t           pending_results[$];
  int unsigned        mismatch_count;
  int unsigned        max_gap;
  int unsigned        quiet_cycles;

  indexed_list_engine #(
    .CAPACITY(ListDepth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // applies one operation to the shadow list and returns the word the block should answer
  function automatic ile_res_t apply_list_op(input ile_cmd_t op);
    ile_res_t r;
    int       p;
    int       n;
    logic     full;
    p = int'(op.position);
    n = shadow_list.size();
    full = (n >= int'(ListDepth));
    r.read_value = NoneValue;
    r.status = STATUS_DONE;
    case (op.kind)
      KIND_GET: begin
        if (p < 0 || p >= n) r.status = STATUS_RANGE;
        else r.read_value = shadow_list[p];
      end
      KIND_INS_HD: begin
        if (full) r.status = STATUS_FULL;
        else shadow_list.push_front(op.value_in);
      end
      KIND_INS_TL: begin
        if (full) r.status = STATUS_FULL;
        else shadow_list.push_back(op.value_in);
      end
      KIND_INS_POS: begin
        // range test wins over the full test
        if (p < 0 || p > n) r.status = STATUS_RANGE;
        else if (full) r.status = STATUS_FULL;
        else shadow_list.insert(p, op.value_in);
      end
      KIND_DEL_POS: begin
        if (p < 0 || p >= n) r.status = STATUS_RANGE;
        else shadow_list.delete(p);
      end
      default: begin
        // undefined kinds change nothing
        r.status = STATUS_RANGE;
      end
    endcase
    r.length = 7'(shadow_list.size());
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // drives one command word, holding start until the block takes it;
  // start stays high afterwards so a zero gap keeps back-to-back words flowing
  task automatic send_op(input ile_cmd_t op);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd   <= op;
    // busy is sampled as it stood before the edge
    do @(posedge clk_i); while (busy);
    pending_results.push_back(apply_list_op(op));
  endtask

  task automatic send_fields(input logic [2:0] kind, input int pos,
                             input logic signed [31:0] val);
    ile_cmd_t op;
    op.kind = kind;
    op.position = 16'(pos);
    op.value_in = val;
    send_op(op);
  endtask

  // hold off new words until every owed result word has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // random operation; ins_w and del_w are percent weights, 3 percent undefined kinds, the rest are gets
  function automatic ile_cmd_t random_op(input int unsigned ins_w, input int unsigned del_w);
    ile_cmd_t    op;
    int unsigned r;
    int          n;
    n = shadow_list.size();
    r = $urandom_range(0, 99);
    if (r < 3) begin
      op.kind = KIND_DEL_POS + 3'($urandom_range(1, 3));
    end else if (r < 3 + ins_w) begin
      case ($urandom_range(0, 2))
        0: op.kind = KIND_INS_HD;
        1: op.kind = KIND_INS_TL;
        default: op.kind = KIND_INS_POS;
      endcase
    end else if (r < 3 + ins_w + del_w) begin
      op.kind = KIND_DEL_POS;
    end else begin
      op.kind = KIND_GET;
    end
    // mostly in-range positions, with boundary and wild ones mixed in
    case ($urandom_range(0, 9))
      0: op.position = 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: op.position = 16'(n);
          1: op.position = 16'(n + 1);
          2: op.position = -16'sd1;
          default: op.position = 16'sh7FFF;
        endcase
      end
      default: op.position = 16'($urandom_range(0, n));
    endcase
    case ($urandom_range(0, 7))
      0: op.value_in = 32'sh7FFF_FFFF;
      1: op.value_in = 32'sh8000_0000;
      default: op.value_in = 32'($urandom);
    endcase
    return op;
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned ins_w,
                            input int unsigned del_w, input int unsigned gap_max);
    max_gap = gap_max;
    repeat (count) send_op(random_op(ins_w, del_w));
  endtask

  // empty list: every position is out of range, undefined kinds rejected
  task automatic test_empty_list();
    send_fields(KIND_GET, 0, 32'sd0);
    send_fields(KIND_GET, -1, 32'sd0);
    send_fields(KIND_GET, 32767, 32'sd0);
    send_fields(KIND_DEL_POS, 0, 32'sd0);
    send_fields(KIND_DEL_POS, -32768, 32'sd0);
    send_fields(KIND_INS_POS, 1, 32'sd5);
    send_fields(KIND_INS_POS, -1, 32'sd5);
    send_fields(KIND_DEL_POS + 3'd1, 0, 32'sd0);
    send_fields(KIND_DEL_POS + 3'd2, 0, 32'sd0);
    send_fields(KIND_DEL_POS + 3'd3, -1, -32'sd1);
  endtask

  // each kind of edit, then read back every slot and delete from both ends
  task automatic test_edit_and_read();
    send_fields(KIND_INS_TL, 0, 32'sh7FFF_FFFF);
    send_fields(KIND_INS_HD, 0, 32'sh8000_0000);
    send_fields(KIND_INS_POS, 1, 32'sd0);
    send_fields(KIND_INS_POS, 3, -32'sd1);     // position equal to length appends
    send_fields(KIND_INS_POS, -32768, 32'sd9);
    send_fields(KIND_INS_POS, 5, 32'sd9);
    send_fields(KIND_GET, 0, 32'sd0);
    send_fields(KIND_GET, 1, 32'sd0);
    send_fields(KIND_GET, 2, 32'sd0);
    send_fields(KIND_GET, 3, 32'sd0);
    send_fields(KIND_GET, 4, 32'sd0);
    send_fields(KIND_DEL_POS, 3, 32'sd0);      // last entry
    send_fields(KIND_DEL_POS, 0, 32'sd0);      // head
    send_fields(KIND_DEL_POS, 2, 32'sd0);      // one past the end
    send_fields(KIND_GET, 1, 32'sd0);
  endtask

  // insert-heavy traffic: reaches capacity and stays there, hitting full rejects
  task automatic test_grow_to_full();
    run_random(350, 75, 10, 4);
  endtask

  // back-to-back words with no idle cycles between them, apart from waits while busy is high
  task automatic test_back_to_back();
    run_random(300, 40, 35, 0);
  endtask

  // delete-heavy traffic: drains the list down to empty and works around zero
  task automatic test_shrink_to_empty();
    run_random(300, 20, 65, 4);
  endtask

  task automatic test_mixed();
    run_random(275, 45, 40, 4);
  endtask

  // result checker: every strobed word is matched against the oldest owed one
  always @(posedge clk_i) begin
    ile_res_t want;
    if (rst_ni && res_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word with none owed: value %0d status %0d length %0d",
                                  res.read_value, res.status, res.length));
      end else begin
        want = pending_results.pop_front();
        if (res.read_value !== want.read_value)
          report_mismatch($sformatf("read_value %0d, want %0d", res.read_value,
                                    want.read_value));
        if (res.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", res.status, want.status));
        if (res.length !== want.length)
          report_mismatch($sformatf("length %0d, want %0d", res.length, want.length));
      end
    end
  end

  // watchdog: a word moving in either direction clears the count
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("tb_indexed_list_engine: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cmd = '0;
    mismatch_count = 0;
    quiet_cycles = 0;
    max_gap = 4;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_edit_and_read();
    wait_drained();
    test_grow_to_full();
    wait_drained();
    test_back_to_back();
    test_shrink_to_empty();
    wait_drained();
    test_mixed();

    // let the last words come back, then give a late shift time to finish
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_indexed_list_engine: done, clean");
    end else begin
      $display("tb_indexed_list_engine: done, errors");
    end
    $finish;
  end

endmodule
